### hdl/two_opt_tour_improver_assert.svh
// Assertion macros used by the checker file of the tour improver.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef TWO_OPT_TOUR_IMPROVER_ASSERT_SVH
`define TWO_OPT_TOUR_IMPROVER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TOI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TOI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/two_opt_pkg.sv
package two_opt_pkg;

    // Default sizing of the cost matrix and of a cost entry.
    localparam int MAX_CITIES_DEF = 32;
    localparam int COST_BITS_DEF  = 16;

    // Fixed field widths of the stream items.
    localparam int TOUR_DEPTH     = 32;
    localparam int POS_W          = 5;
    localparam int CITY_W         = 5;
    localparam int LEN_W          = 6;
    localparam int FUNC_W         = 2;
    localparam int IN_COST_W      = 16;
    localparam int OUT_COST_W     = 21;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 32;
    localparam int TOUR_LEN_RESET = 2;

    // Function codes carried in the input tuser.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_COST = 2'd0,
        FUNC_LOAD_TOUR = 2'd1,
        FUNC_RUN       = 2'd2
    } func_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_cost;
        logic load_tour;
        logic run_init;
        logic eval_issue;
        logic decide;
        logic copy_issue;
        logic next_pair;
        logic emit_issue;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic eval_end;
        logic pos_end;
        logic pipe_busy;
        logic better;
        logic first;
        logic has_next;
        logic out_busy;
    } dp_sts_t;

endpackage

### hdl/two_opt_ram.sv
module two_opt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/two_opt_ctrl.sv
module two_opt_ctrl
    import two_opt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [FUNC_W-1:0] s_tuser,
    input  dp_sts_t           sts,
    output dp_cmd_t           cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_INIT  = 7'b0000010,
        S_EVAL  = 7'b0000100,
        S_DRAIN = 7'b0001000,
        S_COPY  = 7'b0010000,
        S_NEXT  = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_xfer;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (func_t'(s_tuser))
                        FUNC_LOAD_COST: cmd.load_cost = 1'b1;
                        FUNC_LOAD_TOUR: cmd.load_tour = 1'b1;
                        FUNC_RUN:       state_next = S_INIT;
                        default:        state_next = S_IDLE;
                    endcase
                end
            end
            S_INIT:
            begin
                cmd.run_init = 1'b1;
                state_next   = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval_issue = 1'b1;
                if (sts.eval_end)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    cmd.decide = 1'b1;
                    if (sts.better && !sts.first)
                    begin
                        state_next = S_COPY;
                    end
                    else
                    begin
                        state_next = S_NEXT;
                    end
                end
            end
            S_COPY:
            begin
                cmd.copy_issue = 1'b1;
                if (sts.pos_end)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                cmd.next_pair = 1'b1;
                if (sts.has_next)
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.emit_issue = 1'b1;
                    if (sts.pos_end)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/two_opt_dp.sv
module two_opt_dp
    import two_opt_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF,
    parameter int COST_BITS  = COST_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [LEN_W-1:0]      cfg_data,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts,
    input  logic [CITY_W-1:0]     row_city,
    input  logic [CITY_W-1:0]     col_city,
    input  logic [IN_COST_W-1:0]  cost_value,
    input  logic [POS_W-1:0]      tour_position,
    input  logic [CITY_W-1:0]     city_at_position,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [POS_W-1:0]      out_position,
    output logic [CITY_W-1:0]     out_city,
    output logic [OUT_COST_W-1:0] tour_cost,
    output logic                  out_last
);

    localparam int MAT_CB    = $clog2(MAX_CITIES);
    localparam int MAT_AW    = 2 * MAT_CB;
    localparam int MAT_DEPTH = 1 << MAT_AW;
    localparam int SUM_W     = COST_BITS + $clog2(TOUR_DEPTH);
    localparam int TOUR_MAX  = (MAX_CITIES < TOUR_DEPTH) ? MAX_CITIES : TOUR_DEPTH;
    localparam logic [63:0] OUT_COST_MAX = (64'd1 << OUT_COST_W) - 64'd1;

    // Control registers.
    logic [LEN_W-1:0] len_reg;
    logic             first_reg;
    logic [SUM_W-1:0] bc_reg;
    logic             rd1_vld_reg;
    logic             rd2_vld_reg;
    logic             cp_vld_reg;
    logic             er_vld_reg;
    logic             out_vld_reg;

    // Counters and payload registers.
    logic [LEN_W-1:0]      n_reg;
    logic [POS_W-1:0]      i_reg;
    logic [POS_W-1:0]      k_reg;
    logic [LEN_W-1:0]      p_reg;
    logic [SUM_W-1:0]      acc_reg;
    logic [LEN_W-1:0]      rd1_pos_reg;
    logic [CITY_W-1:0]     prev_city_reg;
    logic                  rd2_inr_reg;
    logic [POS_W-1:0]      cp_pos_reg;
    logic [POS_W-1:0]      er_pos_reg;
    logic                  er_last_reg;
    logic [POS_W-1:0]      out_pos_reg;
    logic [CITY_W-1:0]     out_city_reg;
    logic [OUT_COST_W-1:0] out_cost_reg;
    logic                  out_last_reg;

    // Memory ports.
    logic                 cost_we;
    logic [MAT_AW-1:0]    cost_waddr;
    logic [COST_BITS-1:0] cost_wdata;
    logic [MAT_AW-1:0]    cost_raddr;
    logic [COST_BITS-1:0] cost_rdata;
    logic                 best_we;
    logic [POS_W-1:0]     best_waddr;
    logic [CITY_W-1:0]    best_wdata;
    logic [POS_W-1:0]     best_raddr;
    logic [CITY_W-1:0]    best_rdata;
    logic                 cand_we;
    logic [CITY_W-1:0]    cand_rdata;

    // Derived values.
    logic [LEN_W-1:0]      act_len;
    logic [LEN_W-1:0]      mirror;
    logic [POS_W-1:0]      eval_addr;
    logic                  edge_ok;
    logic [OUT_COST_W-1:0] cost_sat;

    function automatic logic city_ok(input logic [CITY_W-1:0] c);
        return (32'(c) < 32'(MAX_CITIES));
    endfunction

    // Tour length clamped to the supported range.
    always_comb
    begin
        if (len_reg < LEN_W'(2))
        begin
            act_len = LEN_W'(2);
        end
        else if (32'(len_reg) > 32'(TOUR_MAX))
        begin
            act_len = LEN_W'(TOUR_MAX);
        end
        else
        begin
            act_len = len_reg;
        end
    end

    // Candidate position p reads the best tour at the mirrored place inside the span;
    // the extra step at p equal to n rereads the start city to close the tour.
    assign mirror = {1'b0, i_reg} + {1'b0, k_reg} - p_reg;

    always_comb
    begin
        if (p_reg == n_reg)
        begin
            eval_addr = '0;
        end
        else if ((p_reg >= {1'b0, i_reg}) && (p_reg <= {1'b0, k_reg}))
        begin
            eval_addr = mirror[POS_W-1:0];
        end
        else
        begin
            eval_addr = p_reg[POS_W-1:0];
        end
    end

    assign best_raddr = cmd.emit_issue ? p_reg[POS_W-1:0] : eval_addr;

    // Cost matrix writes from load items, dropped for cities outside the matrix.
    assign cost_we    = cmd.load_cost && city_ok(row_city) && city_ok(col_city);
    assign cost_waddr = {MAT_CB'(row_city), MAT_CB'(col_city)};
    assign cost_wdata = COST_BITS'(cost_value);

    // Edge lookup between the previous and the current candidate city.
    assign cost_raddr = {MAT_CB'(prev_city_reg), MAT_CB'(best_rdata)};
    assign edge_ok    = city_ok(prev_city_reg) && city_ok(best_rdata);

    // Best tour writes come from tour loads or from copying a kept candidate.
    always_comb
    begin
        if (cp_vld_reg)
        begin
            best_we    = 1'b1;
            best_waddr = cp_pos_reg;
            best_wdata = cand_rdata;
        end
        else
        begin
            best_we    = cmd.load_tour;
            best_waddr = tour_position;
            best_wdata = city_at_position;
        end
    end

    assign cand_we = rd1_vld_reg && (rd1_pos_reg < n_reg);

    // Reported cost saturates at the field width.
    assign cost_sat = (64'(bc_reg) > OUT_COST_MAX) ? '1 : OUT_COST_W'(bc_reg);

    two_opt_ram #(
        .WIDTH (COST_BITS),
        .DEPTH (MAT_DEPTH)
    ) u_cost_ram (
        .clk   (clk),
        .we    (cost_we),
        .waddr (cost_waddr),
        .wdata (cost_wdata),
        .raddr (cost_raddr),
        .rdata (cost_rdata)
    );

    two_opt_ram #(
        .WIDTH (CITY_W),
        .DEPTH (TOUR_DEPTH)
    ) u_best_ram (
        .clk   (clk),
        .we    (best_we),
        .waddr (best_waddr),
        .wdata (best_wdata),
        .raddr (best_raddr),
        .rdata (best_rdata)
    );

    two_opt_ram #(
        .WIDTH (CITY_W),
        .DEPTH (TOUR_DEPTH)
    ) u_cand_ram (
        .clk   (clk),
        .we    (cand_we),
        .waddr (rd1_pos_reg[POS_W-1:0]),
        .wdata (best_rdata),
        .raddr (p_reg[POS_W-1:0]),
        .rdata (cand_rdata)
    );

    // Control state: configuration, stage valids and the kept cost.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= LEN_W'(TOUR_LEN_RESET);
            first_reg   <= 1'b0;
            bc_reg      <= '0;
            rd1_vld_reg <= 1'b0;
            rd2_vld_reg <= 1'b0;
            cp_vld_reg  <= 1'b0;
            er_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                len_reg <= cfg_data;
            end
            if (cmd.run_init)
            begin
                first_reg <= 1'b1;
            end
            else if (cmd.decide)
            begin
                first_reg <= 1'b0;
                if (sts.better)
                begin
                    bc_reg <= acc_reg;
                end
            end
            rd1_vld_reg <= cmd.eval_issue;
            rd2_vld_reg <= rd1_vld_reg && (rd1_pos_reg != '0);
            cp_vld_reg  <= cmd.copy_issue;
            er_vld_reg  <= cmd.emit_issue;
            if (er_vld_reg)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Counters, pipeline payload and output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.run_init)
        begin
            n_reg <= act_len;
            i_reg <= POS_W'(1);
            k_reg <= POS_W'(1);
        end
        else if (cmd.next_pair)
        begin
            if (({1'b0, k_reg} + LEN_W'(1)) < n_reg)
            begin
                k_reg <= k_reg + POS_W'(1);
            end
            else
            begin
                i_reg <= i_reg + POS_W'(1);
                k_reg <= i_reg + POS_W'(2);
            end
        end

        if (cmd.run_init || cmd.decide || cmd.next_pair)
        begin
            p_reg <= '0;
        end
        else if (cmd.eval_issue || cmd.copy_issue || cmd.emit_issue)
        begin
            p_reg <= p_reg + LEN_W'(1);
        end

        // Closed-tour sum of the candidate, one edge per cycle.
        if (cmd.run_init || cmd.next_pair)
        begin
            acc_reg <= '0;
        end
        else if (rd2_vld_reg && rd2_inr_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(cost_rdata);
        end

        rd1_pos_reg <= p_reg;
        if (rd1_vld_reg)
        begin
            prev_city_reg <= best_rdata;
        end
        rd2_inr_reg <= edge_ok;

        cp_pos_reg  <= p_reg[POS_W-1:0];
        er_pos_reg  <= p_reg[POS_W-1:0];
        er_last_reg <= sts.pos_end;

        if (er_vld_reg)
        begin
            out_pos_reg  <= er_pos_reg;
            out_city_reg <= best_rdata;
            out_cost_reg <= cost_sat;
            out_last_reg <= er_last_reg;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        sts           = '0;
        sts.eval_end  = (p_reg == n_reg);
        sts.pos_end   = (p_reg == (n_reg - LEN_W'(1)));
        sts.pipe_busy = rd1_vld_reg || rd2_vld_reg;
        sts.better    = first_reg || (acc_reg < bc_reg);
        sts.first     = first_reg;
        sts.has_next  = (({1'b0, k_reg} + LEN_W'(1)) < n_reg)
                        || (({1'b0, i_reg} + LEN_W'(2)) < n_reg);
        sts.out_busy  = out_vld_reg || er_vld_reg;
    end

    assign out_valid    = out_vld_reg;
    assign out_position = out_pos_reg;
    assign out_city     = out_city_reg;
    assign tour_cost    = out_cost_reg;
    assign out_last     = out_last_reg;

endmodule

### hdl/two_opt_tour_improver.sv
// One 2-opt pass over a closed tour. Load items (tuser 0 for a cost entry, tuser 1 for a
// tour entry) are taken one per cycle. A run item (tuser 2) evaluates the starting tour
// and then every reversal of positions i..k with 1 <= i < k < n, n being the clamped
// tour length; a reversal is kept only when its closed-tour cost is strictly lower.
// The tour memory and the cost memory each give one tour position per cycle to a candidate,
// and every kept candidate is copied back to the tour memory. The improved tour then leaves
// one city at a time, the next read only once the last is taken, with its cost on every
// item and tlast on the final city. Input is not taken while a run is in progress; the user
// writes tour_length on the cfg channel only while idle, which the block does not enforce.
module two_opt_tour_improver
    import two_opt_pkg::*;
#(
    parameter int MAX_CITIES = MAX_CITIES_DEF,
    parameter int COST_BITS  = COST_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // row_city[4:0], col_city[9:5], cost_value[25:10], tour_position[30:26],
    // city_at_position[35:31], zero fill above
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [FUNC_W-1:0]      s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_position[4:0], out_city[9:5], tour_cost[30:10], zero fill above
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [LEN_W-1:0]       cfg_data
);

    dp_cmd_t               cmd;
    dp_sts_t               sts;
    logic [POS_W-1:0]      out_position;
    logic [CITY_W-1:0]     out_city;
    logic [OUT_COST_W-1:0] tour_cost;

    assign cfg_ready = 1'b1;

    two_opt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    two_opt_dp #(
        .MAX_CITIES (MAX_CITIES),
        .COST_BITS  (COST_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .sts              (sts),
        .row_city         (s_tdata[4:0]),
        .col_city         (s_tdata[9:5]),
        .cost_value       (s_tdata[25:10]),
        .tour_position    (s_tdata[30:26]),
        .city_at_position (s_tdata[35:31]),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_position     (out_position),
        .out_city         (out_city),
        .tour_cost        (tour_cost),
        .out_last         (m_tlast)
    );

    // Result packing, lowest field first.
    assign m_tdata = {1'b0, tour_cost, out_city, out_position};

endmodule

### hdl/two_opt_chk.sv
`include "two_opt_tour_improver_assert.svh"

module two_opt_chk
    import two_opt_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast
);

    // A stalled result holds its contents.
    `TOI_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")

    // Positions of one emitted tour count up by one.
    `TOI_ASSERT_NXT(a_pos_step, m_tvalid && m_tready && !m_tlast, !m_tvalid || (m_tdata[4:0] == $past(m_tdata[4:0]) + 5'd1), "tour position skipped")

    // Every city of one emitted tour carries the same cost.
    `TOI_ASSERT_NXT(a_cost_same, m_tvalid && m_tready && !m_tlast, !m_tvalid || (m_tdata[30:10] == $past(m_tdata[30:10])), "tour cost changed within a tour")

    // The final city is never followed at once by another result.
    `TOI_ASSERT_NXT(a_last_gap, m_tvalid && m_tready && m_tlast, !m_tvalid, "result right after the final city")

endmodule

bind two_opt_tour_improver two_opt_chk u_chk (.*);

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import two_opt_pkg::*;

    // Function code that the block must ignore.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int unsigned OUT_COST_MAX = (1 << OUT_COST_W) - 1;
    localparam int ITEM_TARGET   = 470;
    localparam int PHASE_A_END   = 150;
    localparam int PHASE_B_END   = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT   = 200000;

    // One input transfer: func travels in tuser, everything else in tdata.
    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [CITY_W-1:0]    row;
        logic [CITY_W-1:0]    col;
        logic [IN_COST_W-1:0] cost;
        logic [POS_W-1:0]     pos;
        logic [CITY_W-1:0]    city;
    } tour_cmd_t;

    // One emitted city of the improved tour.
    typedef struct packed {
        logic [POS_W-1:0]      pos;
        logic [CITY_W-1:0]     city;
        logic [OUT_COST_W-1:0] cost;
        logic                  last;
    } tour_city_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [FUNC_W-1:0]      s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [LEN_W-1:0]       cfg_data = '0;

    // Predictor state: a copy of the block's memories and its length register.
    logic [IN_COST_W-1:0] cost_mem [MAX_CITIES_DEF][MAX_CITIES_DEF];
    logic [CITY_W-1:0]    tour_mem [TOUR_DEPTH];
    logic [CITY_W-1:0]    best_tour [TOUR_DEPTH];
    logic [CITY_W-1:0]    cand_tour [TOUR_DEPTH];
    logic [LEN_W-1:0]     tour_len_reg = LEN_W'(TOUR_LEN_RESET);

    // Stimulus bookkeeping: which entries hold data, so no unwritten read is caused.
    bit                   cost_known [MAX_CITIES_DEF][MAX_CITIES_DEF];
    bit                   tour_known [TOUR_DEPTH];
    bit                   city_seen [TOUR_DEPTH];
    logic [CITY_W-1:0]    palette [8];
    int                   queued_items = 0;

    tour_cmd_t  command_q [$];
    tour_city_t improved_tour_q [$];
    tour_cmd_t  held_cmd;
    tour_city_t want;
    int         items_taken = 0;
    int         mismatches = 0;
    int         stall_cycles = 0;

    two_opt_tour_improver uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Length register values outside 2..32 are clamped by the block.
    function automatic int active_len(input logic [LEN_W-1:0] v);
        int n;
        n = v;
        if (n < 2)
            n = 2;
        if (n > TOUR_DEPTH)
            n = TOUR_DEPTH;
        return n;
    endfunction

    // Closed-tour cost of the candidate tour over its first n positions.
    function automatic logic [31:0] candidate_cost(input int n);
        logic [31:0] sum;
        int q;
        sum = '0;
        for (int p = 0; p < n; p++)
        begin
            q = (p + 1 == n) ? 0 : p + 1;
            sum += cost_mem[cand_tour[p]][cand_tour[q]];
        end
        return sum;
    endfunction

    // One 2-opt pass; the kept tour goes back to the tour memory and is emitted.
    task automatic improve_tour();
        int n;
        int lo;
        int hi;
        logic [31:0] bc;
        logic [31:0] cc;
        logic [CITY_W-1:0] tmp;
        tour_city_t r;
        n = active_len(tour_len_reg);
        for (int p = 0; p < TOUR_DEPTH; p++)
        begin
            best_tour[p] = tour_mem[p];
            cand_tour[p] = tour_mem[p];
        end
        bc = candidate_cost(n);
        for (int i = 1; i < n; i++)
        begin
            for (int k = i + 1; k < n; k++)
            begin
                for (int p = 0; p < TOUR_DEPTH; p++)
                    cand_tour[p] = best_tour[p];
                lo = i;
                hi = k;
                while (lo < hi)
                begin
                    tmp = cand_tour[lo];
                    cand_tour[lo] = cand_tour[hi];
                    cand_tour[hi] = tmp;
                    lo++;
                    hi--;
                end
                cc = candidate_cost(n);
                if (cc < bc)
                begin
                    for (int p = 0; p < TOUR_DEPTH; p++)
                        best_tour[p] = cand_tour[p];
                    bc = cc;
                end
            end
        end
        for (int p = 0; p < TOUR_DEPTH; p++)
            tour_mem[p] = best_tour[p];
        for (int p = 0; p < n; p++)
        begin
            r.pos  = POS_W'(p);
            r.city = best_tour[p];
            r.cost = (bc > OUT_COST_MAX) ? OUT_COST_W'(OUT_COST_MAX) : bc[OUT_COST_W-1:0];
            r.last = (p == n - 1);
            improved_tour_q = {improved_tour_q, r};
        end
    endtask

    // Update the predictor with one accepted input transfer.
    task automatic apply_cmd(input tour_cmd_t c);
        case (c.func)
            FUNC_LOAD_COST: cost_mem[c.row][c.col] = c.cost;
            FUNC_LOAD_TOUR: tour_mem[c.pos] = c.city;
            FUNC_RUN:       improve_tour();
            default:        ;
        endcase
    endtask

    function automatic int sender_idle_pct();
        if (items_taken < PHASE_A_END)
            return 37;
        if (items_taken < PHASE_B_END)
            return 49;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (items_taken < PHASE_A_END)
            return 49;
        if (items_taken < PHASE_B_END)
            return 37;
        return 0;
    endfunction

    // Input driver: hold the transfer until it is taken, then maybe load the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_cmd(held_cmd);
                items_taken <= items_taken + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (command_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct())
                begin
                    held_cmd = command_q.pop_front();
                    s_tdata  <= {4'b0, held_cmd.city, held_cmd.pos, held_cmd.cost,
                                 held_cmd.col, held_cmd.row};
                    s_tuser  <= held_cmd.func;
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string fname, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, fname, exp_v, act_v);
            mismatches++;
        end
    endtask

    // Output monitor: compare every transfer with the oldest expected city.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (improved_tour_q.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none, actual tdata %h last %b",
                             $time, m_tdata, m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = improved_tour_q.pop_front();
                    check_field("out_position", want.pos, m_tdata[4:0]);
                    check_field("out_city", want.city, m_tdata[9:5]);
                    check_field("tour_cost", want.cost, m_tdata[30:10]);
                    check_field("last", want.last, m_tlast);
                end
            end
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic tour_cmd_t random_cmd();
        tour_cmd_t c;
        c.func = FUNC_W'($urandom_range(0, 3));
        c.row  = CITY_W'($urandom_range(0, 31));
        c.col  = CITY_W'($urandom_range(0, 31));
        c.cost = IN_COST_W'($urandom_range(0, 65535));
        c.pos  = POS_W'($urandom_range(0, 31));
        c.city = CITY_W'($urandom_range(0, 31));
        return c;
    endfunction

    function automatic logic [IN_COST_W-1:0] pick_cost();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return IN_COST_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Queue one transfer and track what it leaves written.
    task automatic queue_cmd(input tour_cmd_t c);
        if (c.func == FUNC_LOAD_COST)
            cost_known[c.row][c.col] = 1'b1;
        if (c.func == FUNC_LOAD_TOUR)
        begin
            tour_known[c.pos]  = 1'b1;
            city_seen[c.city]  = 1'b1;
        end
        command_q = {command_q, c};
        queued_items++;
    endtask

    task automatic queue_cost(input int r, input int c, input logic [IN_COST_W-1:0] v);
        tour_cmd_t t;
        t      = random_cmd();
        t.func = FUNC_LOAD_COST;
        t.row  = CITY_W'(r);
        t.col  = CITY_W'(c);
        t.cost = v;
        queue_cmd(t);
    endtask

    task automatic queue_tour(input int p, input logic [CITY_W-1:0] city);
        tour_cmd_t t;
        t      = random_cmd();
        t.func = FUNC_LOAD_TOUR;
        t.pos  = POS_W'(p);
        t.city = city;
        queue_cmd(t);
    endtask

    task automatic queue_ignored();
        tour_cmd_t t;
        t      = random_cmd();
        t.func = FUNC_UNUSED;
        queue_cmd(t);
    endtask

    // Fill every tour position and cost entry a run can read, then queue the run.
    // Reversals only permute stored cities, so the store never holds a city that was
    // not loaded at some time; costs between all such cities cover every read.
    task automatic queue_run();
        tour_cmd_t t;
        int n;
        n = active_len(tour_len_reg);
        for (int p = 0; p < n; p++)
            if (!tour_known[p])
                queue_tour(p, palette[$urandom_range(0, 7)]);
        for (int a = 0; a < TOUR_DEPTH; a++)
            for (int b = 0; b < TOUR_DEPTH; b++)
                if (city_seen[a] && city_seen[b] && !cost_known[a][b])
                    queue_cost(a, b, pick_cost());
        t      = random_cmd();
        t.func = FUNC_RUN;
        queue_cmd(t);
    endtask

    // Hold off until every queued transfer is taken and every city has come out.
    task automatic drain_block();
        while (items_taken < queued_items || improved_tour_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_tour_length(input logic [LEN_W-1:0] v);
        drain_block();
        @(posedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        tour_len_reg = v;
    endtask

    // Stimulus: directed cases first, then random sessions of loads and runs.
    initial
    begin
        int session;
        int extra;
        int pick;
        bit was_large;
        logic [LEN_W-1:0] len_v;
        for (int a = 0; a < TOUR_DEPTH; a++)
        begin
            tour_known[a] = 1'b0;
            city_seen[a]  = 1'b0;
            for (int b = 0; b < TOUR_DEPTH; b++)
                cost_known[a][b] = 1'b0;
        end
        palette[0] = '0;
        palette[1] = '1;
        for (int p = 2; p < 8; p++)
            palette[p] = CITY_W'($urandom_range(0, 31));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // A length of zero is taken as two; extreme cities, positions and costs.
        set_tour_length(0);
        queue_tour(0, palette[0]);
        queue_tour(1, palette[1]);
        queue_tour(31, palette[1]);
        queue_cost(0, 31, '1);
        queue_cost(31, 0, '1);
        queue_cost(0, 0, '0);
        queue_cost(31, 31, '0);
        queue_run();
        queue_ignored();

        // A length of one is also taken as two.
        set_tour_length(1);
        queue_run();

        // Repeated city in the tour, then every edge at the largest cost.
        set_tour_length(3);
        queue_tour(2, palette[1]);
        queue_run();
        queue_cost(0, 0, '1);
        queue_cost(31, 31, '1);
        queue_run();

        // Random sessions; a few use the longest tour or lengths above the limit.
        session = 0;
        was_large = 1'b0;
        while (queued_items < ITEM_TARGET)
        begin
            if (session == 6 || session == 20 || session == 34)
            begin
                case ($urandom_range(0, 2))
                    0:       len_v = 6'd32;
                    1:       len_v = 6'd33;
                    default: len_v = 6'd63;
                endcase
                set_tour_length(len_v);
                was_large = 1'b1;
            end
            else if (was_large || $urandom_range(0, 1) == 1)
            begin
                if ($urandom_range(0, 7) == 0)
                    len_v = LEN_W'($urandom_range(0, 1));
                else
                    len_v = LEN_W'($urandom_range(2, 8));
                set_tour_length(len_v);
                was_large = 1'b0;
            end
            extra = $urandom_range(0, 6);
            for (int j = 0; j < extra; j++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    queue_cost(palette[$urandom_range(0, 7)], palette[$urandom_range(0, 7)],
                               pick_cost());
                else if (pick < 6)
                    queue_cost($urandom_range(0, 31), $urandom_range(0, 31), pick_cost());
                else if (pick < 9)
                    queue_tour($urandom_range(0, 31), palette[$urandom_range(0, 7)]);
                else
                    queue_ignored();
            end
            queue_run();
            session++;
        end

        drain_block();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/two_opt_pkg.sv
hdl/two_opt_ram.sv
hdl/two_opt_ctrl.sv
hdl/two_opt_dp.sv
hdl/two_opt_tour_improver.sv
hdl/two_opt_chk.sv
tb/testbench.sv
